/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmtc: assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmtc: assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/lmtc_pkg.sv */
`timescale 1ns / 1ps

package lmtc_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [7:0] REG_LCD_ENABLE   = 8'd0;
  localparam logic [7:0] REG_TALL_SPRITES = 8'd1;
  localparam logic [7:0] REG_LINE_COMPARE = 8'd2;
  localparam logic [7:0] REG_STAT_ENABLES = 8'd3;

  localparam int SPRITE_PENALTY = 6;
  localparam int Y_OFFSET       = 16;
  localparam int VISIBLE_LINES  = 144;
  localparam int SHORT_HEIGHT   = 8;
  localparam int TALL_HEIGHT    = 16;

  typedef struct packed {
    logic       command;
    logic [7:0] cycles;
    logic [2:0] fine_scroll_x;
    logic [5:0] slot;
    logic [7:0] slot_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       coincidence;
    logic       vblank_irq;
    logic       status_irq;
    logic       line_drawn;
    logic [3:0] sprites_found;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_item_t;

  function automatic logic stat_level(logic [3:0] en, logic coinc, mode_t mode);
    logic lvl;
    lvl = (en[3] && coinc) ||
          (en[2] && (mode == MODE_SEARCH)) ||
          (en[1] && (mode == MODE_VBLANK)) ||
          (en[0] && (mode == MODE_HBLANK));
    return lvl;
  endfunction

endpackage

/* hdl/lmtc_stream_if.sv */
`timescale 1ns / 1ps

interface lmtc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/lmtc_ram.sv */
`timescale 1ns / 1ps

module lmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lcd_mode_timing_controller_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Payload      Handshake
// in_if    sink       in_item_t    valid/ready
// out_if   source     out_item_t   valid/ready, registered output
// cfg_if   sink       cfg_item_t   valid/ready, ready is always high
//
// A write beat or a tick that does not end sprite search is handled in the idle state.
// A tick that ends sprite search passes through the search and last states, as set by
// the single read port of the slot RAM, which is swept one slot a cycle.
// Reset is synchronous; slot positions read as zero until written, through
// per-slot valid bits, so there is no clearing pass.
// A new input beat is taken only when the controller is idle and the output
// register is empty or being emptied in the same cycle.

module lcd_mode_timing_controller_core
  import lmtc_pkg::*;
#(
  parameter int SPRITE_SLOTS  = 40,
  parameter int MAX_PER_LINE  = 10,
  parameter int SEARCH_CYCLES = 80,
  parameter int DRAW_CYCLES   = 172,
  parameter int LINE_CYCLES   = 456,
  parameter int TOTAL_LINES   = 154
) (
  input  logic          clk,
  input  logic          rst_n,
  lmtc_stream_if.sink   in_if,
  lmtc_stream_if.source out_if,
  lmtc_stream_if.sink   cfg_if
);

`include "assert_macros.svh"

  localparam int SLOT_AW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int SW      = $clog2(MAX_PER_LINE + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_LAST   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [9:0]        cnt_r, cnt_nxt;
  logic [7:0]        line_r, line_nxt;
  mode_t             mode_r, mode_nxt;
  logic [SW-1:0]     spr_r, spr_nxt;
  logic              lvl_r, lvl_nxt;
  logic              en_r, en_nxt;
  logic              tall_r, tall_nxt;
  logic [7:0]        cmp_r, cmp_nxt;
  logic [3:0]        stat_en_r, stat_en_nxt;
  logic [SPRITE_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [SLOT_AW-1:0] idx_r, idx_nxt;
  logic [SW-1:0]     found_r, found_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              vld_q_r, vld_q_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  in_item_t  in_d;
  cfg_item_t cfg_d;
  logic      in_fire;

  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;
  logic [7:0]  slot_pos;
  logic [7:0]  top;
  logic [8:0]  height;
  logic        hit_inc;
  logic [SW-1:0] fin_found;
  logic        s_coinc;

  logic [10:0] sum;
  logic [10:0] thr;
  logic [9:0]  t_cnt;
  logic [7:0]  t_line;
  logic [7:0]  line_inc;
  mode_t       t_mode;
  logic        t_search, t_drawn, t_vbl, t_coinc, t_lvl, w_coinc;

  assign in_d  = in_if.data;
  assign cfg_d = cfg_if.data;

  assign in_if.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
  assign in_fire      = in_if.valid && in_if.ready;

  lmtc_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_d.slot[SLOT_AW-1:0]),
    .wdata (in_d.slot_y),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign slot_pos  = vld_q_r ? ram_rdata : 8'd0;
  assign top       = slot_pos - 8'(Y_OFFSET);
  assign height    = tall_r ? 9'(TALL_HEIGHT) : 9'(SHORT_HEIGHT);
  assign hit_inc   = rd_pend_r && ({1'b0, line_r} >= {1'b0, top}) &&
                     ({1'b0, line_r} < ({1'b0, top} + height)) &&
                     (found_r < SW'(MAX_PER_LINE));
  assign fin_found = found_r + SW'(hit_inc);
  assign s_coinc   = (line_r == cmp_r);
  assign w_coinc   = (line_r == cmp_r);

  always_comb begin
    sum      = {1'b0, cnt_r} + {3'b000, in_d.cycles};
    thr      = 11'(SEARCH_CYCLES + DRAW_CYCLES) + {8'd0, in_d.fine_scroll_x} +
               11'(spr_r) * 11'(SPRITE_PENALTY);
    line_inc = line_r + 8'd1;
    t_cnt    = sum[9:0];
    t_line   = line_r;
    t_mode   = mode_r;
    t_search = 1'b0;
    t_drawn  = 1'b0;
    t_vbl    = 1'b0;
    if (en_r) begin
      case (mode_r)
        MODE_SEARCH: begin
          if (t_cnt >= 10'(SEARCH_CYCLES)) begin
            t_search = 1'b1;
          end
        end
        MODE_DRAW: begin
          if ({1'b0, t_cnt} >= thr) begin
            t_mode  = MODE_HBLANK;
            t_drawn = 1'b1;
          end
        end
        MODE_HBLANK: begin
          if ({1'b0, t_cnt} >= 11'(LINE_CYCLES)) begin
            t_cnt  = 10'd0;
            t_line = line_inc;
            if (line_inc >= 8'(VISIBLE_LINES)) begin
              t_mode = MODE_VBLANK;
              t_vbl  = 1'b1;
            end else begin
              t_mode = MODE_SEARCH;
            end
          end
        end
        default: begin
          if ({1'b0, t_cnt} >= 11'(LINE_CYCLES)) begin
            t_cnt  = 10'd0;
            t_line = line_inc;
            if (line_inc >= 8'(TOTAL_LINES)) begin
              t_line = 8'd0;
              t_mode = MODE_SEARCH;
            end
          end
        end
      endcase
    end else begin
      t_cnt  = 10'd0;
      t_line = 8'd0;
      t_mode = MODE_HBLANK;
    end
    t_coinc = (t_line == cmp_r);
    t_lvl   = stat_level(stat_en_r, t_coinc, t_mode);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    line_nxt      = line_r;
    mode_nxt      = mode_r;
    spr_nxt       = spr_r;
    lvl_nxt       = lvl_r;
    en_nxt        = en_r;
    tall_nxt      = tall_r;
    cmp_nxt       = cmp_r;
    stat_en_nxt   = stat_en_r;
    slot_vld_nxt  = slot_vld_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    rd_pend_nxt   = 1'b0;
    vld_q_nxt     = vld_q_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (cfg_if.valid) begin
      unique case (cfg_d.index)
        REG_LCD_ENABLE:   en_nxt      = cfg_d.value[0];
        REG_TALL_SPRITES: tall_nxt    = cfg_d.value[0];
        REG_LINE_COMPARE: cmp_nxt     = cfg_d.value;
        REG_STAT_ENABLES: stat_en_nxt = cfg_d.value[3:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_d.command == CMD_WRITE) begin
            if ({1'b0, in_d.slot} < 7'(SPRITE_SLOTS)) begin
              ram_we = 1'b1;
              slot_vld_nxt[in_d.slot[SLOT_AW-1:0]] = 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_nxt = '{mode: mode_r, line: line_r, coincidence: w_coinc,
                        vblank_irq: 1'b0, status_irq: 1'b0, line_drawn: 1'b0,
                        sprites_found: 4'(spr_r)};
          end else if (t_search) begin
            cnt_nxt   = t_cnt;
            idx_nxt   = '0;
            found_nxt = '0;
            state_nxt = ST_SEARCH;
          end else begin
            cnt_nxt       = t_cnt;
            line_nxt      = t_line;
            mode_nxt      = t_mode;
            lvl_nxt       = t_lvl;
            out_valid_nxt = 1'b1;
            out_nxt = '{mode: t_mode, line: t_line, coincidence: t_coinc,
                        vblank_irq: t_vbl, status_irq: t_lvl && !lvl_r,
                        line_drawn: t_drawn, sprites_found: 4'(spr_r)};
          end
        end
      end
      ST_SEARCH: begin
        ram_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        vld_q_nxt   = slot_vld_r[idx_r];
        found_nxt   = fin_found;
        idx_nxt     = idx_r + SLOT_AW'(1);
        if (idx_r == SLOT_AW'(SPRITE_SLOTS - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        spr_nxt       = fin_found;
        mode_nxt      = MODE_DRAW;
        lvl_nxt       = stat_level(stat_en_r, s_coinc, MODE_DRAW);
        out_valid_nxt = 1'b1;
        out_nxt = '{mode: MODE_DRAW, line: line_r, coincidence: s_coinc,
                    vblank_irq: 1'b0,
                    status_irq: stat_level(stat_en_r, s_coinc, MODE_DRAW) && !lvl_r,
                    line_drawn: 1'b0, sprites_found: 4'(fin_found)};
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      line_r      <= '0;
      mode_r      <= MODE_HBLANK;
      spr_r       <= '0;
      lvl_r       <= 1'b0;
      en_r        <= 1'b1;
      tall_r      <= 1'b0;
      cmp_r       <= '0;
      stat_en_r   <= '0;
      slot_vld_r  <= '0;
      idx_r       <= '0;
      found_r     <= '0;
      rd_pend_r   <= 1'b0;
      vld_q_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      line_r      <= line_nxt;
      mode_r      <= mode_nxt;
      spr_r       <= spr_nxt;
      lvl_r       <= lvl_nxt;
      en_r        <= en_nxt;
      tall_r      <= tall_nxt;
      cmp_r       <= cmp_nxt;
      stat_en_r   <= stat_en_nxt;
      slot_vld_r  <= slot_vld_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      rd_pend_r   <= rd_pend_nxt;
      vld_q_r     <= vld_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  `ASSERT_IMP(a_busy_no_ready, clk, rst_n, state_r != ST_IDLE, !in_if.ready)
  `ASSERT_NXT(a_last_loads_out, clk, rst_n, state_r == ST_LAST, out_valid_r && out_r.mode == MODE_DRAW)
  `ASSERT_IMP(a_spr_bound, clk, rst_n, 1'b1, spr_r <= SW'(MAX_PER_LINE))
  `ASSERT_IMP(a_line_bound, clk, rst_n, 1'b1, line_r < 8'(TOTAL_LINES))
  `ASSERT_IMP(a_vblank_mode, clk, rst_n, line_r >= 8'(VISIBLE_LINES), mode_r == MODE_VBLANK)
  `ASSERT_IMP(a_vblank_line, clk, rst_n, out_valid_r && out_r.vblank_irq, out_r.line == 8'(VISIBLE_LINES))

endmodule

/* dv/lcd_mode_timing_controller_core_tb.sv */
`timescale 1ns / 1ps

module lcd_mode_timing_controller_core_tb;
  import lmtc_pkg::*;

  localparam int SLOTS         = 40;
  localparam int MAX_PER_LINE  = 10;
  localparam int SEARCH_CYCLES = 80;
  localparam int DRAW_CYCLES   = 172;
  localparam int LINE_CYCLES   = 456;
  localparam int TOTAL_LINES   = 154;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int CHUNKS        = 9;
  localparam int CHUNK_BEATS   = 190;

  class lcd_status_board;
    logic       lcd_on;
    logic       tall_mode;
    logic [7:0] cmp_line;
    logic [3:0] stat_en;
    logic [9:0] dot_count;
    logic [7:0] cur_line;
    mode_t      cur_mode;
    int         sprite_hits;
    logic       stat_prev;
    logic [7:0] slot_pos [SLOTS];
    out_item_t  expected_status [$];
    int         mismatches;

    function new();
      lcd_on      = 1'b1;
      tall_mode   = 1'b0;
      cmp_line    = 8'd0;
      stat_en     = 4'd0;
      dot_count   = 10'd0;
      cur_line    = 8'd0;
      cur_mode    = MODE_HBLANK;
      sprite_hits = 0;
      stat_prev   = 1'b0;
      mismatches  = 0;
      foreach (slot_pos[i]) slot_pos[i] = 8'd0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        REG_LCD_ENABLE:   lcd_on = val[0];
        REG_TALL_SPRITES: tall_mode = val[0];
        REG_LINE_COMPARE: cmp_line = val;
        REG_STAT_ENABLES: stat_en = val[3:0];
        default: ;
      endcase
    endfunction

    // Positions below the offset wrap to the top of the byte range and never cover a line.
    function int scan_line();
      int found;
      int top;
      int height;
      found = 0;
      height = tall_mode ? TALL_HEIGHT : SHORT_HEIGHT;
      for (int i = 0; i < SLOTS && found < MAX_PER_LINE; i++) begin
        top = (int'(slot_pos[i]) - Y_OFFSET) & 255;
        if (int'(cur_line) >= top && int'(cur_line) < top + height) found++;
      end
      return found;
    endfunction

    function void note_beat(in_item_t b);
      out_item_t r;
      logic      lvl;
      r = '0;
      if (b.command == CMD_WRITE) begin
        if (b.slot < SLOTS) slot_pos[b.slot] = b.slot_y;
      end else begin
        if (lcd_on) begin
          dot_count = dot_count + b.cycles;
          case (cur_mode)
            MODE_SEARCH: begin
              if (dot_count >= SEARCH_CYCLES) begin
                sprite_hits = scan_line();
                cur_mode = MODE_DRAW;
              end
            end
            MODE_DRAW: begin
              if (dot_count >= SEARCH_CYCLES + DRAW_CYCLES + int'(b.fine_scroll_x) +
                               sprite_hits * SPRITE_PENALTY) begin
                cur_mode = MODE_HBLANK;
                r.line_drawn = 1'b1;
              end
            end
            MODE_HBLANK: begin
              if (dot_count >= LINE_CYCLES) begin
                dot_count = 10'd0;
                cur_line = cur_line + 8'd1;
                if (cur_line >= VISIBLE_LINES) begin
                  cur_mode = MODE_VBLANK;
                  r.vblank_irq = 1'b1;
                end else begin
                  cur_mode = MODE_SEARCH;
                end
              end
            end
            default: begin
              if (dot_count >= LINE_CYCLES) begin
                dot_count = 10'd0;
                cur_line = cur_line + 8'd1;
                if (cur_line >= TOTAL_LINES) begin
                  cur_line = 8'd0;
                  cur_mode = MODE_SEARCH;
                end
              end
            end
          endcase
        end else begin
          dot_count = 10'd0;
          cur_line = 8'd0;
          cur_mode = MODE_HBLANK;
        end
        lvl = (stat_en[3] && cur_line == cmp_line) ||
              (stat_en[2] && cur_mode == MODE_SEARCH) ||
              (stat_en[1] && cur_mode == MODE_VBLANK) ||
              (stat_en[0] && cur_mode == MODE_HBLANK);
        r.status_irq = lvl && !stat_prev;
        stat_prev = lvl;
      end
      r.mode = cur_mode;
      r.line = cur_line;
      r.coincidence = (cur_line == cmp_line);
      r.sprites_found = sprite_hits[3:0];
      expected_status.push_back(r);
    endfunction

    function void diff_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      diff_field("mode", want.mode, got.mode);
      diff_field("line", want.line, got.line);
      diff_field("coincidence", want.coincidence, got.coincidence);
      diff_field("vblank_irq", want.vblank_irq, got.vblank_irq);
      diff_field("status_irq", want.status_irq, got.status_irq);
      diff_field("line_drawn", want.line_drawn, got.line_drawn);
      diff_field("sprites_found", want.sprites_found, got.sprites_found);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   cycle_count;

  lcd_status_board board = new();

  lmtc_stream_if #(.T(in_item_t))  in_if ();
  lmtc_stream_if #(.T(out_item_t)) out_if ();
  lmtc_stream_if #(.T(cfg_item_t)) cfg_if ();

  lcd_mode_timing_controller_core #(
    .SPRITE_SLOTS  (SLOTS),
    .MAX_PER_LINE  (MAX_PER_LINE),
    .SEARCH_CYCLES (SEARCH_CYCLES),
    .DRAW_CYCLES   (DRAW_CYCLES),
    .LINE_CYCLES   (LINE_CYCLES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lcd_mode_timing_controller_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) board.check_status(out_if.data);
      if (in_if.valid && in_if.ready) board.note_beat(in_if.data);
      if (cfg_if.valid && cfg_if.ready) board.set_reg(cfg_if.data.index, cfg_if.data.value);
    end
  end

  function automatic in_item_t tick(int cyc, int fine);
    in_item_t b;
    b.command = CMD_TICK;
    b.cycles = cyc[7:0];
    b.fine_scroll_x = fine[2:0];
    b.slot = 6'($urandom_range(0, 63));
    b.slot_y = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic in_item_t put_slot(int slot, int pos);
    in_item_t b;
    b.command = CMD_WRITE;
    b.cycles = 8'($urandom_range(0, 255));
    b.fine_scroll_x = 3'($urandom_range(0, 7));
    b.slot = slot[5:0];
    b.slot_y = pos[7:0];
    return b;
  endfunction

  function automatic in_item_t random_beat(int band);
    int r;
    int pos;
    int slot;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      pos = ($urandom_range(0, 9) < 7) ? band + $urandom_range(0, 7) : $urandom_range(0, 255);
      slot = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 39);
      return put_slot(slot, pos);
    end else if (r < 50) begin
      return tick($urandom_range(0, 255), $urandom_range(0, 7));
    end else if (r < 75) begin
      return tick($urandom_range(200, 255), $urandom_range(0, 7));
    end
    return tick($urandom_range(0, 31), $urandom_range(0, 7));
  endfunction

  task automatic send_beat(in_item_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(logic on, logic tall, logic [7:0] cmp, logic [3:0] en);
    cfg_item_t regs [4];
    regs[0].index = REG_LCD_ENABLE;
    regs[0].value = {7'd0, on};
    regs[1].index = REG_TALL_SPRITES;
    regs[1].value = {7'd0, tall};
    regs[2].index = REG_LINE_COMPARE;
    regs[2].value = cmp;
    regs[3].index = REG_STAT_ENABLES;
    regs[3].value = {4'd0, en};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data <= regs[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int         band;
    logic [7:0] cmp;
    logic [3:0] en;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    tx_idle_pct = 8;
    rx_stall_pct = 84;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    write_config(1'b1, 1'b1, 8'd0, 4'd15);
    send_beat(put_slot(0, 16));
    send_beat(put_slot(39, 255));
    send_beat(put_slot(63, 8'h55));
    send_beat(put_slot(40, 0));
    send_beat(put_slot(1, 15));
    send_beat(tick(0, 0));
    send_beat(tick(255, 7));
    send_beat(tick(255, 0));
    send_beat(tick(80, 0));
    send_beat(tick(0, 7));
    send_beat(tick(255, 7));
    send_beat(put_slot(2, 17));
    send_beat(tick(121, 0));
    send_beat(tick(79, 3));
    send_beat(tick(1, 3));
    in_if.valid <= 1'b0;
    drain();

    // With the display off, ticks hold the controller at the top of the frame.
    write_config(1'b0, 1'b1, 8'd0, 4'b1001);
    send_beat(tick(200, 3));
    send_beat(put_slot(5, 100));
    send_beat(tick(255, 7));
    send_beat(tick(0, 0));
    in_if.valid <= 1'b0;
    drain();

    for (int k = 0; k < CHUNKS; k++) begin
      tx_idle_pct = (k < 3) ? 8 : (k < 6) ? 84 : 0;
      rx_stall_pct = (k < 3) ? 84 : (k < 6) ? 8 : 0;
      cmp = (k == 0) ? 8'd255 : (k == 1) ? 8'd0 : 8'($urandom_range(0, 153));
      en = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : (k == 2) ? 4'd8 : 4'($urandom_range(0, 15));
      write_config(1'b1, (k % 2 == 1), cmp, en);
      band = $urandom_range(16, 160);
      for (int n = 0; n < CHUNK_BEATS; n++) begin
        send_beat(random_beat(band));
      end
      in_if.valid <= 1'b0;
      drain();
    end

    repeat (60) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** lcd_mode_timing_controller_core: PASSED **");
    end else begin
      $display("** lcd_mode_timing_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/lmtc_pkg.sv
hdl/lmtc_stream_if.sv
hdl/lmtc_ram.sv
hdl/lcd_mode_timing_controller_core.sv
dv/lcd_mode_timing_controller_core_tb.sv
